[rtl/tpp_pkg.sv]
package tpp_pkg;

  localparam int unsigned MaxColumns = 65536;
  localparam int unsigned CoordW     = 32;
  localparam int unsigned CoeffW     = 16;
  localparam int unsigned DivW       = 48;
  localparam int unsigned DivisorW   = 31;
  localparam int unsigned RemW       = DivisorW + 1;
  localparam int unsigned CfgIdxW    = 4;
  localparam int unsigned CfgDataW   = 64;

  typedef enum logic [CfgIdxW-1:0] {
    RegUpRow      = 4'd0,
    RegDepthRow   = 4'd1,
    RegForwardRow = 4'd2,
    RegFocal      = 4'd3,
    RegCenter     = 4'd4,
    RegGridBase   = 4'd5,
    RegSpacing    = 4'd6,
    RegHeightMap  = 4'd7
  } cfg_reg_e;

  typedef struct packed {
    logic behind;
    logic neg_x;
    logic neg_y;
  } div_tag_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [49:0] v);
    if (v > 50'sd32767) begin
      return 16'sh7fff;
    end else if (v < -50'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

endpackage

[rtl/terrain_perspective_projection.sv]
// Pipeline: 6 front stages, 48 divider stages and 1 output stage lie between the register
// that accepts a request and the output register.
// Throughput: one request per cycle; the 48-stage restoring divider (one quotient
// bit per stage) sets the depth, every stage holds while a result is stalled.
// Reset: asynchronous, active low; clears all valid bits and loads register
// defaults (focal_scale 1.0, all others zero).
module terrain_perspective_projection import tpp_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CfgIdxW-1:0]        cfg_index_i,
  input  logic [CfgDataW-1:0]       cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [23:0]        elevation_i,
  input  logic [15:0]               column_index_i,
  input  logic [15:0]               row_index_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [15:0]        screen_x_o,
  output logic signed [15:0]        screen_y_o,
  output logic                      behind_eye_o,
  output logic                      clipped_o
);

  logic [47:0] up_q, depth_q, fwd_q;
  logic [31:0] focal_q, center_q;
  logic [63:0] base_q, spacing_q, hmap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_q      <= '0;
      depth_q   <= '0;
      fwd_q     <= '0;
      focal_q   <= 32'h0001_0000;
      center_q  <= '0;
      base_q    <= '0;
      spacing_q <= '0;
      hmap_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegUpRow:      up_q      <= cfg_data_i[47:0];
        RegDepthRow:   depth_q   <= cfg_data_i[47:0];
        RegForwardRow: fwd_q     <= cfg_data_i[47:0];
        RegFocal:      focal_q   <= cfg_data_i[31:0];
        RegCenter:     center_q  <= cfg_data_i[31:0];
        RegGridBase:   base_q    <= cfg_data_i;
        RegSpacing:    spacing_q <= cfg_data_i;
        RegHeightMap:  hmap_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic en;
  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  // Stage 1: grid and height products
  logic [16:0]        col_c;
  logic               v1_q;
  logic signed [48:0] pe_q, pn_q;
  logic signed [55:0] ph_q;

  assign col_c = ({1'b0, column_index_i} > 17'(MaxColumns - 1)) ? 17'(MaxColumns - 1)
                                                                : {1'b0, column_index_i};

  always_ff @(posedge clk_i) begin
    if (en) begin
      pe_q <= $signed(col_c) * $signed(spacing_q[31:0]);
      pn_q <= $signed({1'b0, row_index_i}) * $signed(spacing_q[63:32]);
      ph_q <= elevation_i * $signed(hmap_q[31:0]);
    end
  end

  // Stage 2: eye-relative coordinates
  logic               v2_q;
  logic signed [31:0] east_q, north_q, height_q;
  logic signed [47:0] ph_sh;

  assign ph_sh = 48'(ph_q >>> 8);

  always_ff @(posedge clk_i) begin
    if (en) begin
      east_q   <= sat32(64'($signed(base_q[31:0])) + 64'(pe_q));
      north_q  <= sat32(64'($signed(base_q[63:32])) - 64'(pn_q));
      height_q <= sat32(64'(ph_sh) - 64'($signed(hmap_q[63:32])));
    end
  end

  // Stage 3: rotation products, row-major {up, depth, forward} x {h, e, n}
  logic               v3_q;
  logic signed [47:0] rp_q [9];
  logic [47:0]        rows [3];

  assign rows[0] = up_q;
  assign rows[1] = depth_q;
  assign rows[2] = fwd_q;

  for (genvar r = 0; r < 3; r++) begin : g_rot
    always_ff @(posedge clk_i) begin
      if (en) begin
        rp_q[3*r]   <= $signed(rows[r][15:0])  * height_q;
        rp_q[3*r+1] <= $signed(rows[r][31:16]) * east_q;
        rp_q[3*r+2] <= $signed(rows[r][47:32]) * north_q;
      end
    end
  end

  // Stage 4: row sums in Q23.8
  logic               v4_q;
  logic signed [31:0] rv_q [3];

  for (genvar r = 0; r < 3; r++) begin : g_sum
    logic signed [49:0] acc;
    logic signed [35:0] acc_sh;
    assign acc    = 50'(rp_q[3*r]) + 50'(rp_q[3*r+1]) + 50'(rp_q[3*r+2]);
    assign acc_sh = 36'(acc >>> 14);
    always_ff @(posedge clk_i) begin
      if (en) begin
        rv_q[r] <= sat32(64'(acc_sh));
      end
    end
  end

  // Stage 5: focal products
  logic               v5_q;
  logic signed [64:0] nx_q, ny_q;
  logic signed [31:0] fwd5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx_q   <= $signed({1'b0, focal_q}) * rv_q[1];
      ny_q   <= $signed({1'b0, focal_q}) * rv_q[0];
      fwd5_q <= rv_q[2];
    end
  end

  // Stage 6: magnitudes; dividing by fwd*2^16 equals dividing the dropped-16 magnitude by fwd
  logic               v6_q;
  div_tag_t           tag6_q;
  logic [DivW-1:0]    mx_q, my_q;
  logic [DivisorW-1:0] d6_q;
  logic [64:0]        ax, ay;

  assign ax = nx_q[64] ? 65'(-nx_q) : 65'(nx_q);
  assign ay = ny_q[64] ? 65'(-ny_q) : 65'(ny_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      mx_q          <= ax[63:16];
      my_q          <= ay[63:16];
      d6_q          <= fwd5_q[DivisorW-1:0];
      tag6_q.behind <= (fwd5_q <= 32'sd0);
      tag6_q.neg_x  <= nx_q[64];
      tag6_q.neg_y  <= ny_q[64];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  logic            dv;
  div_tag_t        dtag;
  logic [DivW-1:0] qx, qy;

  tpp_div u_div (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (v6_q),
    .tag_i        (tag6_q),
    .dividend_x_i (mx_q),
    .dividend_y_i (my_q),
    .divisor_i    (d6_q),
    .valid_o      (dv),
    .tag_o        (dtag),
    .quotient_x_o (qx),
    .quotient_y_o (qy)
  );

  // Output stage: apply signs, offset from center, saturate; behind-eye items take the center
  logic signed [15:0] cx, cy;
  logic signed [48:0] sqx, sqy;
  logic signed [49:0] sx, sy;
  logic               satx, saty;

  assign cx   = center_q[15:0];
  assign cy   = center_q[31:16];
  assign sqx  = dtag.neg_x ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
  assign sqy  = dtag.neg_y ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
  assign sx   = 50'(cx) + 50'(sqx);
  assign sy   = 50'(cy) - 50'(sqy);
  assign satx = (sx > 50'sd32767) || (sx < -50'sd32768);
  assign saty = (sy > 50'sd32767) || (sy < -50'sd32768);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= dv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      behind_eye_o <= dtag.behind;
      if (dtag.behind) begin
        screen_x_o <= cx;
        screen_y_o <= cy;
        clipped_o  <= 1'b0;
      end else begin
        screen_x_o <= sat16(sx);
        screen_y_o <= sat16(sy);
        clipped_o  <= satx || saty;
      end
    end
  end

  a_behind_center: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && behind_eye_o |-> screen_x_o == $signed(center_q[15:0])
      && screen_y_o == $signed(center_q[31:16]) && !clipped_o)
    else $error("behind-eye result not at screen center");

  a_clip_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && clipped_o |-> screen_x_o == 16'sh7fff || screen_x_o == 16'sh8000
      || screen_y_o == 16'sh7fff || screen_y_o == 16'sh8000)
    else $error("clipped result not at a saturation limit");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  a_clip_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && dv && dtag.behind |=> behind_eye_o && !clipped_o)
    else $error("behind-eye item lost its flag at the output stage");

endmodule

[rtl/tpp_div.sv]
module tpp_div import tpp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  div_tag_t            tag_i,
  input  logic [DivW-1:0]     dividend_x_i,
  input  logic [DivW-1:0]     dividend_y_i,
  input  logic [DivisorW-1:0] divisor_i,
  output logic                valid_o,
  output div_tag_t            tag_o,
  output logic [DivW-1:0]     quotient_x_o,
  output logic [DivW-1:0]     quotient_y_o
);

  // One quotient bit per stage; the dividend register shifts the quotient in.
  logic                v_q   [DivW];
  div_tag_t            tag_q [DivW];
  logic [DivW-1:0]     ax_q  [DivW];
  logic [DivW-1:0]     ay_q  [DivW];
  logic [RemW-1:0]     rx_q  [DivW];
  logic [RemW-1:0]     ry_q  [DivW];
  logic [DivisorW-1:0] d_q   [DivW];

  for (genvar k = 0; k < DivW; k++) begin : g_step
    logic                cur_v;
    div_tag_t            cur_tag;
    logic [DivW-1:0]     cur_ax, cur_ay;
    logic [RemW-1:0]     cur_rx, cur_ry;
    logic [DivisorW-1:0] cur_d;
    logic [RemW-1:0]     sx, sy, dd;
    logic                gx, gy;

    if (k == 0) begin : g_head
      assign cur_v   = valid_i;
      assign cur_tag = tag_i;
      assign cur_ax  = dividend_x_i;
      assign cur_ay  = dividend_y_i;
      assign cur_rx  = '0;
      assign cur_ry  = '0;
      assign cur_d   = divisor_i;
    end else begin : g_body
      assign cur_v   = v_q[k-1];
      assign cur_tag = tag_q[k-1];
      assign cur_ax  = ax_q[k-1];
      assign cur_ay  = ay_q[k-1];
      assign cur_rx  = rx_q[k-1];
      assign cur_ry  = ry_q[k-1];
      assign cur_d   = d_q[k-1];
    end

    assign dd = {1'b0, cur_d};
    assign sx = {cur_rx[RemW-2:0], cur_ax[DivW-1]};
    assign sy = {cur_ry[RemW-2:0], cur_ay[DivW-1]};
    assign gx = (sx >= dd);
    assign gy = (sy >= dd);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= cur_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tag_q[k] <= cur_tag;
        d_q[k]   <= cur_d;
        rx_q[k]  <= gx ? sx - dd : sx;
        ry_q[k]  <= gy ? sy - dd : sy;
        ax_q[k]  <= {cur_ax[DivW-2:0], gx};
        ay_q[k]  <= {cur_ay[DivW-2:0], gy};
      end
    end
  end

  assign valid_o      = v_q[DivW-1];
  assign tag_o        = tag_q[DivW-1];
  assign quotient_x_o = ax_q[DivW-1];
  assign quotient_y_o = ay_q[DivW-1];

endmodule
